### hdl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [BYTE_W-1:0] SINGLE_WILD_RESET = 8'd63;
    localparam logic [BYTE_W-1:0] MULTI_WILD_RESET  = 8'd42;

    localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_WILD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MULTI_WILD  = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // One-cycle command strobes, already qualified by the pipeline advance.
    typedef struct packed {
        logic append;
        logic text;
        logic restart;
        logic clear;
    } cmd_t;

endpackage

### hdl/wpm_pattern_store.sv
// Pattern byte store and fill count.
`timescale 1ns / 1ps

module wpm_pattern_store #(
    parameter int PATTERN_MAX = 32,
    parameter int CNT_W       = 6,
    parameter int IDX_W       = 5
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  wpm_pkg::cmd_t                              cmd,
    input  logic [wpm_pkg::BYTE_W-1:0]                 data_byte,
    output logic [PATTERN_MAX-1:0][wpm_pkg::BYTE_W-1:0] pattern,
    output logic [CNT_W-1:0]                           count,
    output logic [CNT_W-1:0]                           count_next,
    output logic                                       full
);

    logic [PATTERN_MAX-1:0][wpm_pkg::BYTE_W-1:0] store_reg;
    logic [CNT_W-1:0]                            count_reg;

    assign full    = (count_reg == CNT_W'(PATTERN_MAX));
    assign pattern = store_reg;
    assign count   = count_reg;

    always_comb
    begin
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Store entries are payload: no reset, only entries below the count are used.
    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

### hdl/wpm_match_column.sv
// Match column register and its per-item update.
`timescale 1ns / 1ps

module wpm_match_column #(
    parameter int PATTERN_MAX = 32,
    parameter int CNT_W       = 6
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  wpm_pkg::cmd_t                               cmd,
    input  logic [wpm_pkg::BYTE_W-1:0]                  data_byte,
    input  logic [wpm_pkg::BYTE_W-1:0]                  single_wild,
    input  logic [wpm_pkg::BYTE_W-1:0]                  multi_wild,
    input  logic [PATTERN_MAX-1:0][wpm_pkg::BYTE_W-1:0] pattern,
    input  logic [CNT_W-1:0]                            count,
    input  logic [CNT_W-1:0]                            count_next,
    input  logic                                        full,
    output logic                                        matched
);

    localparam int COL_W = PATTERN_MAX + 1;

    logic [COL_W-1:0]                            col_reg;
    logic [COL_W-1:0]                            col_next;
    logic [COL_W-1:0]                            feed_col;
    logic [COL_W-1:0]                            empty_col;
    logic [PATTERN_MAX-1:0][wpm_pkg::BYTE_W-1:0] view;
    logic                                        append_ok;

    assign append_ok = cmd.append && !full;

    // Pattern as it stands after this request: an append shows its byte at once.
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (append_ok && (CNT_W'(k) == count))
            begin
                view[k] = data_byte;
            end
            else
            begin
                view[k] = pattern[k];
            end
        end
    end

    // Empty-text column: prefix of multi wildcards.
    // Text column: literal or single takes the diagonal, multi chains upward.
    always_comb
    begin
        empty_col    = '0;
        empty_col[0] = 1'b1;
        feed_col     = '0;
        for (int i = 1; i < COL_W; i++)
        begin
            if (CNT_W'(i) <= count_next)
            begin
                empty_col[i] = empty_col[i-1] && (view[i-1] == multi_wild);
                if ((view[i-1] == data_byte) || (view[i-1] == single_wild))
                begin
                    feed_col[i] = col_reg[i-1];
                end
                else if (view[i-1] == multi_wild)
                begin
                    feed_col[i] = feed_col[i-1] || col_reg[i];
                end
                else
                begin
                    feed_col[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            col_next = COL_W'(1);
        end
        else if (append_ok || cmd.restart)
        begin
            col_next = empty_col;
        end
        else if (cmd.text)
        begin
            col_next = feed_col;
        end
        else
        begin
            col_next = col_reg;
        end
    end

    assign matched = col_next[count_next];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= COL_W'(1);
        end
        else
        begin
            col_reg <= col_next;
        end
    end

endmodule

### hdl/wildcard_pattern_matcher.sv
// Top level of the streaming wildcard pattern matcher.
//
// Requests enter on s_tvalid/s_tready/s_tdata: an operation (append pattern
// byte, feed text byte, restart text, clear pattern) and a data byte. Each
// request gives exactly one result on m_tvalid/m_tready/m_tdata: whether the
// whole pattern matches the text fed since the last restart, an overflow
// flag for an append to a full store, and the stored pattern length. The user
// sets wildcard bytes through cfg_we/cfg_addr/cfg_wdata while idle (unenforced).
//
// Pipeline: a request is captured in the input register, processed, and its
// result is captured in the result register that drives m_tvalid. Throughput
// is one request per cycle while m_tready does not hold the result; the whole
// match column, including the multi-wildcard chain across all pattern
// positions, updates in a single stage.
// Reset clears the pattern, sets the column to the empty-text value and
// loads the wildcards with '?' and '*'. When m_tready is low the result is
// held, the input register still fills, and s_tready drops only when both
// stages are occupied.
`timescale 1ns / 1ps

module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: [1:0] operation, [9:2] data_byte, [15:10] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wpm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata: [0] matched, [1] status, [7:2] pattern_length
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wpm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [wpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [wpm_pkg::BYTE_W-1:0]          cfg_wdata
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [wpm_pkg::BYTE_W-1:0]                  single_wild_reg;
    logic [wpm_pkg::BYTE_W-1:0]                  multi_wild_reg;
    logic                                        in_valid_reg;
    wpm_pkg::op_t                                in_op_reg;
    logic [wpm_pkg::BYTE_W-1:0]                  in_byte_reg;
    logic                                        out_valid_reg;
    logic [wpm_pkg::OUT_TDATA_W-1:0]             out_data_reg;
    logic                                        advance;
    logic                                        step;
    wpm_pkg::cmd_t                               cmd;
    logic [PATTERN_MAX-1:0][wpm_pkg::BYTE_W-1:0] pattern;
    logic [CNT_W-1:0]                            count;
    logic [CNT_W-1:0]                            count_next;
    logic                                        full;
    logic                                        matched;
    logic                                        status;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_wild_reg <= wpm_pkg::SINGLE_WILD_RESET;
            multi_wild_reg  <= wpm_pkg::MULTI_WILD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wpm_pkg::CFG_SINGLE_WILD: single_wild_reg <= cfg_wdata;
                wpm_pkg::CFG_MULTI_WILD:  multi_wild_reg  <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= wpm_pkg::op_t'(s_tdata[wpm_pkg::OP_W-1:0]);
            in_byte_reg <= s_tdata[wpm_pkg::OP_W +: wpm_pkg::BYTE_W];
        end
    end

    always_comb
    begin
        cmd = '0;
        if (step)
        begin
            case (in_op_reg)
                wpm_pkg::OP_APPEND:  cmd.append  = 1'b1;
                wpm_pkg::OP_TEXT:    cmd.text    = 1'b1;
                wpm_pkg::OP_RESTART: cmd.restart = 1'b1;
                wpm_pkg::OP_CLEAR:   cmd.clear   = 1'b1;
                default:             cmd         = '0;
            endcase
        end
    end

    wpm_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (in_byte_reg),
        .pattern    (pattern),
        .count      (count),
        .count_next (count_next),
        .full       (full)
    );

    wpm_match_column #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_column (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_byte_reg),
        .single_wild (single_wild_reg),
        .multi_wild  (multi_wild_reg),
        .pattern     (pattern),
        .count       (count),
        .count_next  (count_next),
        .full        (full),
        .matched     (matched)
    );

    assign status = cmd.append && full;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {wpm_pkg::LEN_W'(count_next), status, matched};
        end
    end

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("s_tready low with a free pipeline stage");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (in_op_reg == wpm_pkg::OP_CLEAR))
        |=> (m_tvalid && m_tdata[0] && (m_tdata[7:2] == '0)))
        else $error("clear did not give an empty pattern that matches");

    a_overflow_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[7:2] == wpm_pkg::LEN_W'(PATTERN_MAX)))
        else $error("overflow reported below the store size");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] <= wpm_pkg::LEN_W'(PATTERN_MAX)))
        else $error("pattern length beyond the store size");
`endif

endmodule

### tb/sv/wpm_match_checker.sv
// Checker for the wildcard pattern matcher: predicts each result and compares it.
`timescale 1ns / 1ps

module wpm_match_checker
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [BYTE_W-1:0]      cfg_wdata,
    output int                     fail_count,
    output int                     pending,
    output int                     checked_count,
    output int                     match_count,
    output int                     dropped_count
);

    typedef struct packed {
        logic             matched;
        logic             status;
        logic [LEN_W-1:0] plen;
    } match_result_t;

    // predictor state
    logic [BYTE_W-1:0]    pattern_bytes [PATTERN_MAX];
    logic [LEN_W-1:0]     stored_len  = '0;
    logic [PATTERN_MAX:0] column      = 1;
    logic [BYTE_W-1:0]    single_wild = SINGLE_WILD_RESET;
    logic [BYTE_W-1:0]    multi_wild  = MULTI_WILD_RESET;

    match_result_t expected_results [$];

    int n_fail    = 0;
    int n_pending = 0;
    int n_checked = 0;
    int n_match   = 0;
    int n_dropped = 0;

    assign fail_count    = n_fail;
    assign pending       = n_pending;
    assign checked_count = n_checked;
    assign match_count   = n_match;
    assign dropped_count = n_dropped;

    // Column for empty text: bit i holds while the first i bytes are all multi wildcards.
    function automatic logic [PATTERN_MAX:0] empty_text_column();
        logic [PATTERN_MAX:0] c;
        c = '0;
        c[0] = 1'b1;
        for (int i = 1; i <= PATTERN_MAX; i++)
        begin
            if (i <= stored_len && pattern_bytes[i-1] == multi_wild)
                c[i] = c[i-1];
        end
        return c;
    endfunction

    function automatic logic [PATTERN_MAX:0] advance_column(input logic [BYTE_W-1:0] t);
        logic [PATTERN_MAX:0] nxt;
        logic [BYTE_W-1:0]    p;
        nxt = '0;
        for (int i = 1; i <= PATTERN_MAX; i++)
        begin
            if (i <= stored_len)
            begin
                p = pattern_bytes[i-1];
                // literal equality and the single wildcard both win over the multi wildcard
                if (p == t || p == single_wild)
                    nxt[i] = column[i-1];
                else if (p == multi_wild)
                    nxt[i] = nxt[i-1] | column[i];
            end
        end
        return nxt;
    endfunction

    function automatic match_result_t predict_request(input logic [IN_TDATA_W-1:0] req);
        match_result_t     r;
        op_t               op;
        logic [BYTE_W-1:0] b;
        op = op_t'(req[OP_W-1:0]);
        b  = req[OP_W +: BYTE_W];
        r.status = 1'b0;
        case (op)
            OP_APPEND:
            begin
                if (stored_len >= PATTERN_MAX)
                    r.status = 1'b1;
                else
                begin
                    pattern_bytes[stored_len] = b;
                    stored_len = stored_len + 1'b1;
                    column = empty_text_column();
                end
            end
            OP_TEXT:
                column = advance_column(b);
            OP_RESTART:
                column = empty_text_column();
            OP_CLEAR:
            begin
                stored_len = '0;
                column = 1;
            end
        endcase
        r.matched = column[stored_len];
        r.plen    = stored_len;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_result_t got;
        match_result_t want;
        if (!rst_n)
        begin
            stored_len  = '0;
            column      = 1;
            single_wild = SINGLE_WILD_RESET;
            multi_wild  = MULTI_WILD_RESET;
            expected_results.delete();
            n_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_SINGLE_WILD)
                    single_wild = cfg_wdata;
                else
                    multi_wild = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), predict_request(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.matched = m_tdata[0];
                got.status  = m_tdata[1];
                got.plen    = m_tdata[7:2];
                n_checked++;
                if (got.matched === 1'b1)
                    n_match++;
                if (got.status === 1'b1)
                    n_dropped++;
                if (expected_results.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("%0t: result with no request outstanding, m_tdata=%h",
                                 $realtime, m_tdata);
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (n_fail < 10)
                            $display({"%0t: result %0d mismatch: expected matched=%0d ",
                                      "status=%0d length=%0d, got matched=%0d status=%0d ",
                                      "length=%0d"}, $realtime, n_checked, want.matched,
                                     want.status, want.plen, got.matched, got.status,
                                     got.plen);
                        n_fail++;
                    end
                end
            end
            n_pending <= expected_results.size();
        end
    end

endmodule

### tb/sv/tb_wildcard_pattern_matcher.sv
// Stimulus and verdict for the wildcard pattern matcher.
`timescale 1ns / 1ps

module tb_wildcard_pattern_matcher;
    import wpm_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [BYTE_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked_count;
    int match_count;
    int dropped_count;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int sent_count = 0;

    // what the stimulus believes is stored, used to build matching text
    logic [BYTE_W-1:0] shadow_pattern [$];
    logic [BYTE_W-1:0] cur_single = SINGLE_WILD_RESET;
    logic [BYTE_W-1:0] cur_multi  = MULTI_WILD_RESET;

    logic [BYTE_W-1:0] single_settings [PHASES] = '{8'd63, 8'd0, 8'd255, 8'd42, 8'd97,
                                                    8'd0, 8'd63};
    logic [BYTE_W-1:0] multi_settings [PHASES]  = '{8'd42, 8'd255, 8'd0, 8'd63, 8'd97,
                                                    8'd0, 8'd42};

    always #1 clk = ~clk;

    wildcard_pattern_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    wpm_match_checker #(
        .PATTERN_MAX(PATTERN_MAX)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .fail_count(fail_count),
        .pending(pending),
        .checked_count(checked_count),
        .match_count(match_count),
        .dropped_count(dropped_count)
    );

    always @(posedge clk)
        m_tready <= rx_quiet || ($urandom_range(0, 99) >= 7);

    task automatic send_request(input op_t op, input logic [BYTE_W-1:0] b);
        if (!tx_quiet)
        begin
            while ($urandom_range(0, 99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-OP_W-BYTE_W){1'b0}}, b, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        if (op == OP_APPEND && shadow_pattern.size() < PATTERN_MAX)
            shadow_pattern.insert(shadow_pattern.size(), b);
        else if (op == OP_CLEAR)
            shadow_pattern.delete();
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_wildcards(input logic [BYTE_W-1:0] sw, input logic [BYTE_W-1:0] mw);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SINGLE_WILD;
        cfg_wdata <= sw;
        @(posedge clk);
        cfg_addr  <= CFG_MULTI_WILD;
        cfg_wdata <= mw;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_single = sw;
        cur_multi  = mw;
        @(posedge clk);
    endtask

    // mostly a tiny alphabet plus the wildcards, so matches actually happen
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'h61 + 8'($urandom_range(0, 2));
        if (r < 58)
            return cur_single;
        if (r < 76)
            return cur_multi;
        return 8'($urandom);
    endfunction

    task automatic run_phase(input int target);
        int r;
        int plen;
        int runs;
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] word [$];
        while (sent_count < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_request(op_t'($urandom_range(0, 3)), 8'($urandom));
            else
            begin
                if (r < 75 || shadow_pattern.size() == 0)
                    send_request(OP_CLEAR, 8'($urandom));
                // a few long patterns, some long enough to run past the store and get dropped
                plen = ($urandom_range(0, 99) < 6) ? $urandom_range(28, 35)
                                                   : $urandom_range(1, 6);
                repeat (plen) send_request(OP_APPEND, pick_byte());
                runs = $urandom_range(1, 3);
                for (int k = 0; k < runs; k++)
                begin
                    if (k > 0)
                        send_request(OP_RESTART, 8'($urandom));
                    word.delete();
                    if ($urandom_range(0, 99) < 60)
                    begin
                        // expand the pattern into a text it should accept
                        for (int j = 0; j < shadow_pattern.size(); j++)
                        begin
                            p = shadow_pattern[j];
                            if (p == cur_single)
                                word.insert(word.size(), pick_byte());
                            else if (p == cur_multi)
                                repeat ($urandom_range(0, 3))
                                    word.insert(word.size(), pick_byte());
                            else
                                word.insert(word.size(), p);
                        end
                        if (word.size() > 0 && $urandom_range(0, 99) < 20)
                            word[$urandom_range(0, word.size() - 1)] = pick_byte();
                    end
                    else
                        repeat ($urandom_range(0, 10)) word.insert(word.size(), pick_byte());
                    foreach (word[i])
                        send_request(OP_TEXT, word[i]);
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests with the reset wildcards '?' and '*'
        send_request(OP_CLEAR, 8'h00);
        send_request(OP_TEXT, 8'h00);     // empty pattern against one byte
        send_request(OP_RESTART, 8'h00);  // empty pattern, empty text
        send_request(OP_APPEND, 8'h2a);
        send_request(OP_TEXT, 8'hff);
        send_request(OP_APPEND, 8'h61);
        send_request(OP_TEXT, 8'h78);
        send_request(OP_TEXT, 8'h61);
        send_request(OP_APPEND, 8'h3f);
        send_request(OP_TEXT, 8'h61);
        send_request(OP_TEXT, 8'h2a);     // star in text under '?'
        send_request(OP_RESTART, 8'hff);
        send_request(OP_TEXT, 8'h2a);     // star in text meets star in pattern as a literal
        send_request(OP_TEXT, 8'h61);
        send_request(OP_TEXT, 8'h3f);
        send_request(OP_TEXT, 8'h62);
        send_request(OP_CLEAR, 8'hff);
        send_request(OP_APPEND, 8'h00);
        send_request(OP_APPEND, 8'hff);
        send_request(OP_TEXT, 8'h00);
        send_request(OP_TEXT, 8'hff);
        send_request(OP_RESTART, 8'h55);
        send_request(OP_TEXT, 8'hff);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 5)
                program_wildcards(8'($urandom), 8'($urandom));
            else
                program_wildcards(single_settings[ph], multi_settings[ph]);
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3);
            run_phase(sent_count + PHASE_ITEMS);
        end

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d requests over %0d wildcard settings; %0d results checked",
                 sent_count, PHASES, checked_count);
        $display("Full-pattern matches seen: %0d, appends dropped on a full store: %0d",
                 match_count, dropped_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/wpm_pkg.sv
hdl/wpm_pattern_store.sv
hdl/wpm_match_column.sv
hdl/wildcard_pattern_matcher.sv
tb/sv/wpm_match_checker.sv
tb/sv/tb_wildcard_pattern_matcher.sv
